FILE: hw/rtl/png_row_unfilter_top_assert.svh
// Assertion macros shared by the row unfilter modules.
`ifndef PNG_ROW_UNFILTER_TOP_ASSERT_SVH
`define PNG_ROW_UNFILTER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/pru_pkg.sv
// Shared types and constants for the PNG row unfilter.
package pru_pkg;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 16;

  localparam logic [CFG_AW-1:0] CFG_BPP       = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_ROW_BYTES = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_HEIGHT    = 2'd2;

  localparam logic [7:0] FILT_MAX_CODE = 8'd4;

  // Per-item control passed from the front end to the back end.
  typedef struct packed {
    logic  is_err;
    logic  first_row;
    logic  row_start;
    logic  last_row;
    logic  last_img;
    filt_t filt;
  } ctl_t;

endpackage

FILE: hw/rtl/pru_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/pru_fifo.sv
// Short register queue between the front end and the back end.
module pru_fifo #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(DEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`include "png_row_unfilter_top_assert.svh"

  `PRU_ASSERT_NOW(a_no_overflow, push, cnt_r != CW'(DEPTH), "push into full queue")
  `PRU_ASSERT_NOW(a_no_underflow, pop, cnt_r != '0, "pop from empty queue")

endmodule

FILE: hw/rtl/pru_front.sv
// Front end: tracks row position, row count and errors, classifies each item.
module pru_front
  import pru_pkg::*;
#(
  parameter int MAX_ROW_BYTES = 4096,
  parameter int AW = $clog2(MAX_ROW_BYTES),
  parameter int PW = $clog2(MAX_ROW_BYTES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          in_first,
  input  logic [PW-1:0] row_len,
  input  logic [15:0]   height,
  input  logic          q_full,
  output logic          push,
  output ctl_t          push_ctl,
  output logic [7:0]    push_byte,
  output logic [AW-1:0] push_idx
);

  logic [PW-1:0] pos_r, pos_nxt;
  logic [15:0]   row_r, row_nxt;
  logic          err_r, err_nxt;
  filt_t         filt_r, filt_nxt;

  logic          acc;
  logic [PW-1:0] pos;
  logic [15:0]   row;
  logic          err;
  logic          row_end;
  logic          kept;

  assign in_ready  = !q_full;
  assign acc       = in_valid && in_ready;
  assign push_byte = in_byte;

  always_comb begin
    // a new image restarts at the filter byte of row 0
    pos     = in_first ? '0 : pos_r;
    row     = in_first ? '0 : row_r;
    err     = in_first ? 1'b0 : err_r;
    row_end = (pos >= row_len);
    kept    = (row < height);
    push_idx = AW'(pos - 1'b1);

    pos_nxt  = pos_r;
    row_nxt  = row_r;
    err_nxt  = err_r;
    filt_nxt = filt_r;
    push     = 1'b0;

    push_ctl           = '0;
    push_ctl.filt      = filt_r;
    push_ctl.first_row = (row == '0);
    push_ctl.row_start = (pos == PW'(1));
    push_ctl.last_row  = row_end;
    push_ctl.last_img  = row_end && ({1'b0, row} + 17'd1 == {1'b0, height});

    if (acc) begin
      pos_nxt = pos;
      row_nxt = row;
      err_nxt = err;
      if (!err) begin
        if (pos == '0) begin
          pos_nxt = PW'(1);
          if (kept) begin
            if (in_byte > FILT_MAX_CODE) begin
              err_nxt  = 1'b1;
              push     = 1'b1;
              push_ctl = '0;
              push_ctl.is_err = 1'b1;
            end else begin
              filt_nxt = filt_t'(in_byte[2:0]);
            end
          end
        end else begin
          push = kept;
          if (row_end) begin
            pos_nxt = '0;
            row_nxt = row + 16'(kept);
          end else begin
            pos_nxt = pos + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      row_r  <= '0;
      err_r  <= 1'b0;
      filt_r <= FILT_NONE;
    end else begin
      pos_r  <= pos_nxt;
      row_r  <= row_nxt;
      err_r  <= err_nxt;
      filt_r <= filt_nxt;
    end
  end

endmodule

FILE: hw/rtl/pru_back.sv
// Back end: prior-row store, left/upper-left history and byte reconstruction.
module pru_back
  import pru_pkg::*;
#(
  parameter int MAX_ROW_BYTES   = 4096,
  parameter int MAX_PIXEL_BYTES = 8,
  parameter int AW = $clog2(MAX_ROW_BYTES),
  parameter int HW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  ctl_t          q_ctl,
  input  logic [7:0]    q_byte,
  input  logic [AW-1:0] q_idx,
  output logic          q_pop,
  input  logic [HW-1:0] bpp_idx,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_byte,
  output logic          out_last_row,
  output logic          out_last_img,
  output logic          out_bad
);

  logic          s1_v_r;
  ctl_t          s1_ctl_r;
  logic [7:0]    s1_byte_r;
  logic [AW-1:0] s1_idx_r;
  logic          byp_r;
  logic [7:0]    byp_d_r;

  logic [7:0] left_r [MAX_PIXEL_BYTES];
  logic [7:0] up_r   [MAX_PIXEL_BYTES];

  logic       out_v_r;
  logic [7:0] out_byte_r;
  logic       out_last_row_r, out_last_img_r, out_bad_r;

  logic       s1_fire, s1_adv;
  logic       ram_we;
  logic [7:0] ram_rd;
  logic [7:0] a, b, c, pred, rec;
  logic [8:0] sum_ab;
  logic signed [9:0] da, db, dc;
  logic [9:0] pa, pb, pc;

  assign s1_fire = s1_v_r && (!out_v_r || out_tready);
  assign s1_adv  = !s1_v_r || s1_fire;
  assign q_pop   = q_valid && s1_adv;
  assign ram_we  = s1_fire && !s1_ctl_r.is_err;

  pru_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROW_BYTES),
    .AW    (AW)
  ) u_prior_row (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_idx_r),
    .wdata (rec),
    .re    (q_pop),
    .raddr (q_idx),
    .rdata (ram_rd)
  );

  always_comb begin
    a = s1_ctl_r.row_start ? 8'd0 : left_r[bpp_idx];
    c = s1_ctl_r.row_start ? 8'd0 : up_r[bpp_idx];
    // the byte written by the item just ahead is not yet visible in the RAM
    b = s1_ctl_r.first_row ? 8'd0 : (byp_r ? byp_d_r : ram_rd);

    sum_ab = {1'b0, a} + {1'b0, b};
    da = 10'(signed'({2'b00, b})) - 10'(signed'({2'b00, c}));
    db = 10'(signed'({2'b00, a})) - 10'(signed'({2'b00, c}));
    dc = da + db;
    pa = (da < 0) ? 10'(-da) : 10'(da);
    pb = (db < 0) ? 10'(-db) : 10'(db);
    pc = (dc < 0) ? 10'(-dc) : 10'(dc);

    unique case (s1_ctl_r.filt)
      FILT_NONE:  pred = 8'd0;
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = sum_ab[8:1];
      FILT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default:    pred = 8'd0;
    endcase
    rec = s1_byte_r + pred;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (q_pop) begin
      s1_v_r <= 1'b1;
    end else if (s1_fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_ctl_r  <= q_ctl;
      s1_byte_r <= q_byte;
      s1_idx_r  <= q_idx;
      byp_r     <= ram_we && (s1_idx_r == q_idx);
      byp_d_r   <= rec;
    end
  end

  // newest byte in slot 0; a row start drops the previous row's bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        left_r[k] <= 8'd0;
        up_r[k]   <= 8'd0;
      end
    end else if (ram_we) begin
      left_r[0] <= rec;
      up_r[0]   <= b;
      for (int k = 1; k < MAX_PIXEL_BYTES; k++) begin
        left_r[k] <= s1_ctl_r.row_start ? 8'd0 : left_r[k-1];
        up_r[k]   <= s1_ctl_r.row_start ? 8'd0 : up_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_fire) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_byte_r     <= s1_ctl_r.is_err ? 8'd0 : rec;
      out_last_row_r <= s1_ctl_r.last_row && !s1_ctl_r.is_err;
      out_last_img_r <= s1_ctl_r.last_img && !s1_ctl_r.is_err;
      out_bad_r      <= s1_ctl_r.is_err;
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_byte     = out_byte_r;
  assign out_last_row = out_last_row_r;
  assign out_last_img = out_last_img_r;
  assign out_bad      = out_bad_r;

`include "png_row_unfilter_top_assert.svh"

  `PRU_ASSERT_NOW(a_ram_wr_data, ram_we, s1_v_r && !s1_ctl_r.is_err, "row store write w/o data item")
  `PRU_ASSERT_NOW(a_bad_clean, out_tvalid && out_bad, out_byte == 8'd0 && !out_last_row && !out_last_img, "error item carries data")
  `PRU_ASSERT_NOW(a_img_end_row, out_tvalid && out_last_img, out_last_row, "image end not on row end")

endmodule

FILE: hw/rtl/png_row_unfilter_top.sv
// PNG scanline unfilter top level: config registers, front end, queue, back end.
//
//  channel | dir | handshake                | payload
//  --------+-----+--------------------------+------------------------------------------
//  in_     | in  | in_tvalid / in_tready    | tdata: data_byte; tuser: first_of_image
//  out_    | out | out_tvalid / out_tready  | tdata: out_byte; tlast: last_of_row;
//          |     |                          | tuser: last_of_image, bad_filter
//  cfg_    | in  | cfg_we                   | cfg_addr, cfg_wdata
//
// Sustains one item per cycle while out_tready stays high; an accepted data byte passes
// through the queue, the reconstruct stage and the output register before it is presented.
// The rate is set by the reconstruct stage: left-neighbor feedback plus Paeth select,
// both combinational there, and one read and one write of the prior-row RAM per byte.
// Reset is synchronous; no clearing pass, since the first row never uses data read from the row store.
// The queue decouples the input from output stalls; in_tready drops only when it fills.
module png_row_unfilter_top
  import pru_pkg::*;
#(
  parameter int MAX_ROW_BYTES   = 4096,
  parameter int MAX_PIXEL_BYTES = 8,
  parameter int QUEUE_DEPTH     = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] data_byte
  input  logic              in_tuser,   // [0] first_of_image
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [7:0] out_byte
  output logic              out_tlast,
  output logic [1:0]        out_tuser,  // [0] last_of_image, [1] bad_filter
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_ROW_BYTES);
  localparam int PW = $clog2(MAX_ROW_BYTES + 1);
  localparam int LW = (PW > 13) ? PW : 13;
  localparam int HW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int QW = $bits(ctl_t) + 8 + AW;

  logic [3:0]  bpp_r;
  logic [12:0] row_bytes_r;
  logic [15:0] height_r;

  logic [LW-1:0] rb_ext;
  logic [PW-1:0] row_len;
  logic [15:0]   height;
  logic [HW-1:0] bpp_idx;

  logic          push, q_full, q_pop, q_valid;
  ctl_t          push_ctl, q_ctl;
  logic [7:0]    push_byte, q_byte;
  logic [AW-1:0] push_idx, q_idx;
  logic [QW-1:0] q_pop_data;
  logic          out_last_img, out_bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r       <= 4'd1;
      row_bytes_r <= 13'd1;
      height_r    <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_BPP:       bpp_r       <= cfg_wdata[3:0];
        CFG_ROW_BYTES: row_bytes_r <= cfg_wdata[12:0];
        CFG_HEIGHT:    height_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // out-of-range settings clamp to the nearest legal value
  always_comb begin
    rb_ext = LW'(row_bytes_r);
    if (rb_ext == '0) begin
      row_len = PW'(1);
    end else if (rb_ext > LW'(MAX_ROW_BYTES)) begin
      row_len = PW'(MAX_ROW_BYTES);
    end else begin
      row_len = PW'(rb_ext);
    end
    height = (height_r == '0) ? 16'd1 : height_r;
    if (bpp_r == '0) begin
      bpp_idx = '0;
    end else if (bpp_r > 4'(MAX_PIXEL_BYTES)) begin
      bpp_idx = HW'(MAX_PIXEL_BYTES - 1);
    end else begin
      bpp_idx = HW'(bpp_r - 4'd1);
    end
  end

  pru_front #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES),
    .AW            (AW),
    .PW            (PW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_first  (in_tuser),
    .row_len   (row_len),
    .height    (height),
    .q_full    (q_full),
    .push      (push),
    .push_ctl  (push_ctl),
    .push_byte (push_byte),
    .push_idx  (push_idx)
  );

  pru_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_ctl, push_byte, push_idx}),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_pop_data)
  );

  assign {q_ctl, q_byte, q_idx} = q_pop_data;

  pru_back #(
    .MAX_ROW_BYTES   (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
    .AW              (AW),
    .HW              (HW)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_ctl        (q_ctl),
    .q_byte       (q_byte),
    .q_idx        (q_idx),
    .q_pop        (q_pop),
    .bpp_idx      (bpp_idx),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_byte     (out_tdata),
    .out_last_row (out_tlast),
    .out_last_img (out_last_img),
    .out_bad      (out_bad)
  );

  assign out_tuser = {out_bad, out_last_img};

endmodule
